@@ hw/rtl/open_address_hash_set_macros.svh @@
// Assertion macros for the hash set checker.
`ifndef OPEN_ADDRESS_HASH_SET_MACROS_SVH
`define OPEN_ADDRESS_HASH_SET_MACROS_SVH
// implication checked on every edge outside reset
`define OAHS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define OAHS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ hw/rtl/oahs_pkg.sv @@
// ----------------------------------------------------------------------------
// oahs_pkg
// Types and constants for the open-address hash set.
// ----------------------------------------------------------------------------
package oahs_pkg;
	localparam int SLOT_BITS_DEF = 10;
	localparam int KEY_BITS_DEF  = 32;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_REM = 2'd1;
	localparam logic [1:0] OP_QRY = 2'd2;
	localparam logic [1:0] OP_NOP = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_RSV  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] key;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        hit;
		logic [31:0] old_key;
		logic [9:0]  slot;
		logic [10:0] live_total;
	} out_beat_t;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_READ, S_CHECK, S_WRITE, S_DONE
	} fsm_t;

	function automatic logic [16:0] probe_poly(input int bits);
		case (bits)
			2: probe_poly = 17'd7;
			3: probe_poly = 17'd11;
			4: probe_poly = 17'd19;
			5: probe_poly = 17'd37;
			6: probe_poly = 17'd67;
			7: probe_poly = 17'd131;
			8: probe_poly = 17'd285;
			9: probe_poly = 17'd529;
			10: probe_poly = 17'd1033;
			11: probe_poly = 17'd2053;
			12: probe_poly = 17'd4179;
			13: probe_poly = 17'd8219;
			14: probe_poly = 17'd16427;
			15: probe_poly = 17'd32771;
			default: probe_poly = 17'd65581;
		endcase
	endfunction
endpackage

@@ hw/rtl/open_address_hash_set.sv @@
// ----------------------------------------------------------------------------
// open_address_hash_set
// Open-addressing key set in one slot memory with tombstones.
// ----------------------------------------------------------------------------
// channel   dir  handshake           payload
// cmd       in   start & !busy       cmd  (op, key)
// result    out  done (one cycle)    result (status, hit, old_key, slot, live_total)
//
// After reset a clearing pass writes every slot empty, with busy high. An item
// passes the accept state, a read and a check state per probe, a write state when
// the set changes, and the result state. Probe walks are up to 2^SLOT_BITS probes,
// run once (query/remove) or twice (add after a miss), all on the one slot memory
// with registered read data. Reserved keys and unused ops go from accept straight
// to the result. The receiver cannot stall; busy stays high until the result beat.
module open_address_hash_set #(
	parameter int SLOT_BITS = oahs_pkg::SLOT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  oahs_pkg::in_beat_t cmd,
	output logic               busy,
	output logic               done,
	output oahs_pkg::out_beat_t result
);
	import oahs_pkg::*;
	localparam int SLOTS = 1 << SLOT_BITS;
	localparam logic [SLOT_BITS-1:0] MASK = {SLOT_BITS{1'b1}};
	localparam logic [16:0] POLY_FULL = probe_poly(SLOT_BITS);
	localparam logic [SLOT_BITS:0] POLY = POLY_FULL[SLOT_BITS:0];

	logic [31:0] mem [SLOTS];
	logic [31:0] rd_q;

	fsm_t state_q, state_d;
	logic [1:0]  op_q;
	logic [31:0] key_q;
	logic [SLOT_BITS-1:0] base_q, incr_q, idx_q;
	logic [SLOT_BITS-1:0] incr0_q;
	logic [SLOT_BITS:0]   n_q;
	logic        pass2_q;
	logic [10:0] live_q;
	logic [SLOT_BITS-1:0] clr_q;
	out_beat_t res_q;

	logic we;
	logic [SLOT_BITS-1:0] waddr, raddr;
	logic [31:0] wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	logic stop, is_tomb, is_eq, rsv;
	logic [SLOT_BITS:0] incr_sh;
	logic [SLOT_BITS-1:0] incr_nx, incr0, incr_raw;
	assign is_tomb = (rd_q == '1);
	assign is_eq = (rd_q == key_q);
	assign stop = (rd_q == '0) || (is_tomb ? pass2_q : is_eq);
	assign incr_sh = {incr_q, 1'b0};
	assign incr_nx = incr_sh[SLOT_BITS] ? incr_sh[SLOT_BITS-1:0] ^ POLY[SLOT_BITS-1:0]
		: incr_sh[SLOT_BITS-1:0];
	assign rsv = (cmd.key == '0) || (cmd.key == '1);
	assign incr_raw = cmd.key[SLOT_BITS-1:0] ^ cmd.key[SLOT_BITS+2:3];
	assign incr0 = (incr_raw == '0) ? MASK : incr_raw;

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = idx_q;
		wdata = key_q;
		raddr = idx_q;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1; waddr = clr_q; wdata = '0;
				if (clr_q == MASK) state_d = S_IDLE;
			end
			S_IDLE: if (start) state_d = (cmd.op == OP_NOP || rsv) ? S_DONE : S_READ;
			S_READ: state_d = S_CHECK;
			S_CHECK: begin
				if (stop) begin
					if (op_q == OP_ADD && (pass2_q || !is_eq)) begin
						if (pass2_q) state_d = S_WRITE;
						else state_d = S_READ;
					end else if (op_q == OP_REM && is_eq) state_d = S_WRITE;
					else state_d = S_DONE;
				end else if (n_q == SLOTS[SLOT_BITS:0] - 1'b1) begin
					state_d = (op_q == OP_ADD && !pass2_q) ? S_READ : S_DONE;
				end else state_d = S_READ;
			end
			S_WRITE: begin
				we = 1'b1;
				wdata = (op_q == OP_REM) ? '1 : key_q;
				state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			live_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_WRITE) live_q <= (op_q == OP_REM) ? live_q - 11'd1 : live_q + 11'd1;
		end
	end

	logic [SLOT_BITS-1:0] nxt_idx;
	assign nxt_idx = base_q + ((n_q == '0) ? incr_q : incr_nx);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q <= cmd.op;
				key_q <= cmd.key;
				base_q <= ~cmd.key[SLOT_BITS-1:0];
				idx_q <= ~cmd.key[SLOT_BITS-1:0];
				incr_q <= incr0;
				n_q <= '0;
				pass2_q <= 1'b0;
				res_q.status <= (cmd.op != OP_NOP && rsv) ? ST_RSV : ST_DONE;
				res_q.hit <= 1'b0;
				res_q.old_key <= '0;
				res_q.slot <= '0;
				res_q.live_total <= '0;
			end
			S_CHECK: begin
				if (stop) begin
					res_q.slot <= 10'(idx_q);
					if (is_eq && !pass2_q) begin
						res_q.old_key <= key_q;
						res_q.hit <= (op_q != OP_ADD);
					end
					if (op_q == OP_ADD && (pass2_q || !is_eq)) res_q.hit <= pass2_q;
				end else if (n_q == SLOTS[SLOT_BITS:0] - 1'b1 && (op_q != OP_ADD || pass2_q))
					res_q.status <= ST_FULL;
				if ((stop || n_q == SLOTS[SLOT_BITS:0] - 1'b1) && op_q == OP_ADD && !pass2_q
					&& !(stop && is_eq)) begin
					pass2_q <= 1'b1;
					idx_q <= base_q;
					incr_q <= incr0_q;
					n_q <= '0;
				end else if (!stop) begin
					idx_q <= nxt_idx;
					if (n_q != '0) incr_q <= incr_nx;
					n_q <= n_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// first step kept for the second pass
	always_ff @(posedge clk) if (state_q == S_IDLE) incr0_q <= incr0;

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	always_comb begin
		result = res_q;
		result.live_total = live_q;
	end
endmodule

@@ hw/rtl/oahs_checker.sv @@
// ----------------------------------------------------------------------------
// oahs_checker
// Port-level checks for the hash set.
// ----------------------------------------------------------------------------
`include "open_address_hash_set_macros.svh"
module oahs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input oahs_pkg::out_beat_t result
);
	import oahs_pkg::*;
	`OAHS_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy)
	`OAHS_ASSERT_NXT(a_done_frees, clk, arst_n, done, !busy)
	`OAHS_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`OAHS_ASSERT_IMP(a_full_nohit, clk, arst_n, done && result.status != ST_DONE, !result.hit)
endmodule

bind open_address_hash_set oahs_checker u_chk (.*);
